### sv/positional_list_store_assert.svh
// Assertion macros for the positional list store checker.
// Needs no other file; the including file passes its clock and reset names.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PLS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_list_store check failed");

// Next-cycle implication, disabled while reset is low.
`define PLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_list_store check failed");

`endif

### sv/pls_pkg.sv
// Types, sizes and codes for the positional list store.
// No dependencies; used by the cell, chain, top-level and checker files.
`default_nettype none
package pls_pkg;

  localparam int Depth      = 16;
  localparam int ValueWidth = 32;

  // Fixed field widths of the stream beats.
  localparam int CmdW  = 3;
  localparam int PosW  = 5;
  localparam int InValW = 32;
  localparam int StW   = 2;
  localparam int OutIdxW = 4;
  localparam int OutLenW = 5;

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam int CmpW = (PosW > CntW) ? PosW : CntW;

  localparam int InDataW  = 40;
  localparam int OutDataW = 48;

  typedef logic [ValueWidth-1:0] value_t;
  typedef value_t [Depth-1:0] entries_t;

  typedef enum logic [CmdW-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_UPDATE    = 3'd6,
    CMD_TRAVERSE  = 3'd7
  } cmd_e;

  typedef enum logic [StW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_UPD  = 2'd3
  } cell_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_TRAV = 1'b1
  } state_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e          op;
    logic [CmpW-1:0]   pos;
    value_t            value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### sv/pls_cell.sv
// One storage cell of the list row: holds one entry, shifts with its neighbors.
// Depends on pls_pkg.
`default_nettype none
module pls_cell (
  input  logic                   clk_i,
  input  pls_pkg::cell_ctrl_t    ctrl_i,
  input  logic [pls_pkg::IdxW-1:0] cell_idx_i,
  input  pls_pkg::value_t        left_i,
  input  pls_pkg::value_t        right_i,
  output pls_pkg::value_t        entry_o
);

  pls_pkg::value_t entry_q, entry_d;
  logic [pls_pkg::CmpW-1:0] idx;

  assign idx = pls_pkg::CmpW'(cell_idx_i);

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      pls_pkg::CELL_HOLD: entry_d = entry_q;
      pls_pkg::CELL_INS: begin
        if (idx > ctrl_i.pos) begin
          entry_d = left_i;
        end else if (idx == ctrl_i.pos) begin
          entry_d = ctrl_i.value;
        end
      end
      pls_pkg::CELL_DEL: begin
        if (idx >= ctrl_i.pos) begin
          entry_d = right_i;
        end
      end
      pls_pkg::CELL_UPD: begin
        if (idx == ctrl_i.pos) begin
          entry_d = ctrl_i.value;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

### sv/pls_chain.sv
// Row of Depth list cells, each linked to its left and right neighbor.
// Depends on pls_pkg and pls_cell.
`default_nettype none
module pls_chain (
  input  logic                clk_i,
  input  pls_pkg::cell_ctrl_t ctrl_i,
  output pls_pkg::entries_t   entries_o
);

  pls_pkg::entries_t entries;

  for (genvar i = 0; i < pls_pkg::Depth; i++) begin : g_cell
    pls_pkg::value_t left, right;
    // Ends feed their own entry; a delete loads it into the last cell.
    if (i == 0) begin : g_first
      assign left = entries[i];
    end else begin : g_left
      assign left = entries[i-1];
    end
    if (i == pls_pkg::Depth - 1) begin : g_last
      assign right = entries[i];
    end else begin : g_right
      assign right = entries[i+1];
    end

    pls_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .cell_idx_i (pls_pkg::IdxW'(i)),
      .left_i     (left),
      .right_i    (right),
      .entry_o    (entries[i])
    );
  end

  assign entries_o = entries;

endmodule
`default_nettype wire

### sv/positional_list_store.sv
// Top level of the positional list store: command decode, traverse sequencer,
// output register. Depends on pls_pkg and pls_chain.
//
//  channel  dir  tdata fields (low bit up)                          tlast
//  s_axis   in   command[2:0] position[7:3] value[39:8]             -
//  m_axis   out  status[1:0] element_value[33:2] element_index[37:34]
//                list_length[42:38] zero[47:43]                     last
//
// Edits and updates act on all cells of the row at once; inserts and deletes
// shift cells from the position on. Traverse: elements are read from the row
// through a single indexed port into the output register, in index order.
// Input is held off while a traverse streams; a stalled output holds its beat.
// Reset clears the length and the handshake state; entries are left as is.
`default_nettype none
module positional_list_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // command, position, value
  input  logic [pls_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status, element_value, element_index, list_length, zero pad
  output logic [pls_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);

  pls_pkg::state_e state_q, state_d;
  logic [pls_pkg::CntW-1:0] count_q, count_d;
  logic [pls_pkg::IdxW-1:0] trav_idx_q, trav_idx_d;

  logic                         out_valid_q;
  pls_pkg::status_e             out_status_q;
  logic [pls_pkg::InValW-1:0]   out_value_q;
  logic [pls_pkg::OutIdxW-1:0]  out_idx_q;
  logic [pls_pkg::OutLenW-1:0]  out_len_q;
  logic                         out_last_q;

  logic out_free, in_fire, trav_emit, trav_last;
  pls_pkg::cmd_e cmd;
  logic [pls_pkg::CmpW-1:0] pos, cnt;
  logic signed [pls_pkg::InValW-1:0] in_value;
  pls_pkg::status_e status;
  pls_pkg::cell_op_e op;
  logic [pls_pkg::CmpW-1:0] eff_pos;
  logic [pls_pkg::CntW-1:0] new_count;
  pls_pkg::cell_ctrl_t ctrl;
  pls_pkg::entries_t entries;
  pls_pkg::value_t trav_entry;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;

  assign cmd      = pls_pkg::cmd_e'(s_axis_tdata_i[2:0]);
  assign pos      = pls_pkg::CmpW'(s_axis_tdata_i[7:3]);
  assign in_value = s_axis_tdata_i[39:8];
  assign cnt      = pls_pkg::CmpW'(count_q);

  // Command decode and bounds checks.
  always_comb begin
    status    = pls_pkg::STAT_OK;
    op        = pls_pkg::CELL_HOLD;
    eff_pos   = pos;
    new_count = count_q;
    unique case (cmd)
      pls_pkg::CMD_INS_FRONT, pls_pkg::CMD_INS_BACK, pls_pkg::CMD_INS_AT: begin
        if (cmd == pls_pkg::CMD_INS_FRONT) begin
          eff_pos = '0;
        end else if (cmd == pls_pkg::CMD_INS_BACK) begin
          eff_pos = cnt;
        end
        if (count_q == pls_pkg::CntW'(pls_pkg::Depth)) begin
          status = pls_pkg::STAT_FULL;
        end else if (eff_pos > cnt) begin
          status = pls_pkg::STAT_RANGE;
        end else begin
          op        = pls_pkg::CELL_INS;
          new_count = count_q + pls_pkg::CntW'(1);
        end
      end
      pls_pkg::CMD_DEL_FRONT, pls_pkg::CMD_DEL_BACK, pls_pkg::CMD_DEL_AT: begin
        if (cmd == pls_pkg::CMD_DEL_FRONT) begin
          eff_pos = '0;
        end else if (cmd == pls_pkg::CMD_DEL_BACK) begin
          eff_pos = cnt - pls_pkg::CmpW'(1);
        end
        if (count_q == '0) begin
          status = pls_pkg::STAT_EMPTY;
        end else if (eff_pos >= cnt) begin
          status = pls_pkg::STAT_RANGE;
        end else begin
          op        = pls_pkg::CELL_DEL;
          new_count = count_q - pls_pkg::CntW'(1);
        end
      end
      pls_pkg::CMD_UPDATE: begin
        if (count_q == '0) begin
          status = pls_pkg::STAT_EMPTY;
        end else if (pos >= cnt) begin
          status = pls_pkg::STAT_RANGE;
        end else begin
          op = pls_pkg::CELL_UPD;
        end
      end
      pls_pkg::CMD_TRAVERSE: begin
        if (count_q == '0) begin
          status = pls_pkg::STAT_EMPTY;
        end
      end
      default: status = pls_pkg::STAT_OK;
    endcase
  end

  always_comb begin
    ctrl.op    = in_fire ? op : pls_pkg::CELL_HOLD;
    ctrl.pos   = eff_pos;
    ctrl.value = pls_pkg::ValueWidth'(in_value);
  end

  pls_chain u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .entries_o (entries)
  );

  assign trav_entry = entries[trav_idx_q];
  assign trav_last  = (pls_pkg::CntW'(trav_idx_q) + pls_pkg::CntW'(1)) == count_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pls_pkg::ST_IDLE: begin
        if (in_fire && cmd == pls_pkg::CMD_TRAVERSE && count_q != '0) begin
          state_d = pls_pkg::ST_TRAV;
        end
      end
      pls_pkg::ST_TRAV: begin
        if (out_free && trav_last) begin
          state_d = pls_pkg::ST_IDLE;
        end
      end
      default: state_d = pls_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    trav_emit       = 1'b0;
    unique case (state_q)
      pls_pkg::ST_IDLE: s_axis_tready_o = out_free;
      pls_pkg::ST_TRAV: trav_emit = out_free;
      default: s_axis_tready_o = 1'b0;
    endcase
  end

  always_comb begin
    count_d    = count_q;
    trav_idx_d = trav_idx_q;
    if (in_fire) begin
      count_d    = new_count;
      trav_idx_d = '0;
    end else if (trav_emit) begin
      trav_idx_d = trav_idx_q + pls_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pls_pkg::ST_IDLE;
      count_q     <= '0;
      trav_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      trav_idx_q <= trav_idx_d;
      // a non-empty traverse emits its first beat from the sequencer
      if ((in_fire && !(cmd == pls_pkg::CMD_TRAVERSE && count_q != '0)) || trav_emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (trav_emit) begin
      out_status_q <= pls_pkg::STAT_OK;
      out_value_q  <= pls_pkg::InValW'(trav_entry);
      out_idx_q    <= pls_pkg::OutIdxW'(trav_idx_q);
      out_len_q    <= pls_pkg::OutLenW'(count_q);
      out_last_q   <= trav_last;
    end else if (in_fire) begin
      out_status_q <= status;
      out_value_q  <= '0;
      out_idx_q    <= '0;
      out_len_q    <= pls_pkg::OutLenW'(new_count);
      out_last_q   <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {5'd0, out_len_q, out_idx_q, out_value_q, out_status_q};

endmodule
`default_nettype wire

### sv/pls_checker.sv
// Port-level checks for the positional list store, bound to the top level.
// Depends on pls_pkg and positional_list_store_assert.svh.
`default_nettype none
`include "positional_list_store_assert.svh"
module pls_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [pls_pkg::InDataW-1:0]   s_axis_tdata_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [pls_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic                          m_axis_tlast_o
);

  logic mid_beat;
  logic unused_in;

  assign mid_beat  = m_axis_tvalid_o && !m_axis_tlast_o;
  assign unused_in = s_axis_tvalid_i ^ (^s_axis_tdata_i);

  // stalled beat holds
  `PLS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
  // only a traverse of a list of two or more entries gives non-final beats, all with ok status
  `PLS_ASSERT_NOW(a_mid_ok, clk_i, rst_ni, mid_beat, m_axis_tdata_o[1:0] == pls_pkg::STAT_OK)
  // input is held off while a traverse streams
  `PLS_ASSERT_NOW(a_mid_no_input, clk_i, rst_ni, mid_beat, !s_axis_tready_o)
  // an empty status always reports a zero length
  `PLS_ASSERT_NOW(a_empty_len, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[1:0] == pls_pkg::STAT_EMPTY, m_axis_tdata_o[42:38] == 5'd0)

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);
`default_nettype wire
